>>> design/wshw_pkg.sv
// ----------------------------------------------------------------------------
// wshw_pkg
// Shared types, sizes and lookup tables for the word stack with high-water
// register.
// ----------------------------------------------------------------------------
package wshw_pkg;

    // Storage size and word width of the stack.
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the channels.
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Derived sizes.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int TBL_N  = 1 << ADDR_W;

    // The entries are spread over three banks so that the top three words
    // always sit in different banks and can be read in the same cycle.
    localparam int NUM_BANKS  = 3;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int BANK_DEPTH = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(64);

    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH  = 3'd0,
        FN_POP1  = 3'd1,
        FN_POP2  = 3'd2,
        FN_POP3  = 3'd3,
        FN_DROP  = 3'd4,
        FN_CLEAR = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Result fields known at accept time, carried alongside the bank reads.
    typedef struct packed {
        status_t             status;
        logic [1:0]          n_pop;
        bank_t               bank1;
        bank_t               bank2;
        bank_t               bank3;
        logic [COUNT_W-1:0]  depth;
        logic [COUNT_W-1:0]  high_water;
    } item_meta_t;

    // Bank write and read requests issued at accept time.
    typedef struct packed {
        logic [NUM_BANKS-1:0]            wr_en;
        row_t                            wr_row;
        logic [WORD_BITS-1:0]            wr_data;
        logic [NUM_BANKS-1:0][ROW_W-1:0] rd_row;
    } bank_req_t;

    // Address to bank table, built by counting at elaboration.
    function automatic logic [TBL_N*BANK_W-1:0] build_bank_table();
        logic [TBL_N*BANK_W-1:0] tbl;
        bank_t                   m;
        tbl = '0;
        m   = '0;
        for (int i = 0; i < TBL_N; i++) begin
            tbl[i*BANK_W +: BANK_W] = m;
            if (m == BANK_W'(NUM_BANKS - 1)) begin
                m = '0;
            end
            else begin
                m = m + 1'b1;
            end
        end
        return tbl;
    endfunction

    // Address to row table, built the same way.
    function automatic logic [TBL_N*ROW_W-1:0] build_row_table();
        logic [TBL_N*ROW_W-1:0] tbl;
        bank_t                  m;
        row_t                   r;
        tbl = '0;
        m   = '0;
        r   = '0;
        for (int i = 0; i < TBL_N; i++) begin
            tbl[i*ROW_W +: ROW_W] = r;
            if (m == BANK_W'(NUM_BANKS - 1)) begin
                m = '0;
                r = r + 1'b1;
            end
            else begin
                m = m + 1'b1;
            end
        end
        return tbl;
    endfunction

    localparam logic [TBL_N*BANK_W-1:0] BANK_TBL = build_bank_table();
    localparam logic [TBL_N*ROW_W-1:0]  ROW_TBL  = build_row_table();

    function automatic bank_t bank_of(logic [ADDR_W-1:0] a);
        return BANK_TBL[a*BANK_W +: BANK_W];
    endfunction

    function automatic row_t row_of(logic [ADDR_W-1:0] a);
        return ROW_TBL[a*ROW_W +: ROW_W];
    endfunction

endpackage

>>> design/wshw_if.sv
// ----------------------------------------------------------------------------
// wshw_if
// Valid/ready channels of the word stack: command, response and limit write.
// ----------------------------------------------------------------------------

// Command channel: one operation per word.
interface wshw_cmd_if import wshw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DATA_W-1:0]  push_word;
    logic [COUNT_W-1:0] drop_count;

    modport source (output valid, output func, output push_word, output drop_count,
                    input ready);
    modport sink   (input valid, input func, input push_word, input drop_count,
                    output ready);
endinterface

// Response channel: one result per command.
interface wshw_rsp_if import wshw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   first_word;
    logic [DATA_W-1:0]   second_word;
    logic [DATA_W-1:0]   third_word;
    logic [COUNT_W-1:0]  depth;
    logic [COUNT_W-1:0]  high_water;

    modport source (output valid, output status, output first_word, output second_word,
                    output third_word, output depth, output high_water, input ready);
    modport sink   (input valid, input status, input first_word, input second_word,
                    input third_word, input depth, input high_water, output ready);
endinterface

// Limit write channel.
interface wshw_cfg_if import wshw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] stack_limit;

    modport source (output valid, output stack_limit, input ready);
    modport sink   (input valid, input stack_limit, output ready);
endinterface

>>> design/wshw_ram.sv
// ----------------------------------------------------------------------------
// wshw_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module wshw_ram #(
    parameter int WIDTH       = 32,
    parameter int DEPTH_WORDS = 22
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH_WORDS)-1:0] wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH_WORDS)-1:0] rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH_WORDS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/wshw_ctrl.sv
// ----------------------------------------------------------------------------
// wshw_ctrl
// Stack pointer, high-water and limit registers; decodes each command and
// issues the bank writes and reads for it.
// ----------------------------------------------------------------------------
module wshw_ctrl import wshw_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [FUNC_W-1:0]  func,
    input  logic [DATA_W-1:0]  push_word,
    input  logic [COUNT_W-1:0] drop_count,
    input  logic               cfg_wr,
    input  logic [COUNT_W-1:0] cfg_limit,
    output item_meta_t         meta,
    output bank_req_t          req
);

    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   ptr_next;
    logic [CNT_W-1:0]   peak_reg;
    logic [CNT_W-1:0]   peak_next;
    logic [COUNT_W-1:0] limit_reg;

    logic [CMP_W-1:0]   ptr_ext;
    logic [CMP_W-1:0]   lim_ext;
    logic [CMP_W-1:0]   eff_limit;
    status_t            status;
    logic [1:0]         n_pop;
    logic               push_ok;

    logic [ADDR_W-1:0]  addr1;
    logic [ADDR_W-1:0]  addr2;
    logic [ADDR_W-1:0]  addr3;
    logic [ADDR_W-1:0]  wr_addr;
    bank_t              wr_bank;

    // The limit in force never exceeds the storage.
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign lim_ext   = CMP_W'(limit_reg);
    assign eff_limit = (lim_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_ext;

    // Command decode: status and the pointer after the command.
    always_comb
    begin
        status   = ST_OK;
        ptr_next = ptr_reg;
        n_pop    = 2'd0;
        push_ok  = 1'b0;
        unique case (func_t'(func))
            FN_PUSH:
            begin
                if (ptr_ext >= eff_limit)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    push_ok  = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            FN_POP1, FN_POP2, FN_POP3:
            begin
                if (ptr_ext < CMP_W'(func[1:0]))
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    n_pop    = func[1:0];
                    ptr_next = ptr_reg - CNT_W'(func[1:0]);
                end
            end
            FN_DROP:
            begin
                if (CMP_W'(drop_count) > ptr_ext)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    ptr_next = ptr_reg - CNT_W'(drop_count);
                end
            end
            FN_CLEAR:
            begin
                ptr_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Only a push can raise the high-water mark.
    assign peak_next = (push_ok && (ptr_next > peak_reg)) ? ptr_next : peak_reg;

    // Architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            peak_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg  <= ptr_next;
                peak_reg <= peak_next;
            end
            if (cfg_wr)
            begin
                limit_reg <= cfg_limit;
            end
        end
    end

    // Addresses of the three top words and of the push slot.
    assign addr1   = ADDR_W'(ptr_reg - CNT_W'(1));
    assign addr2   = ADDR_W'(ptr_reg - CNT_W'(2));
    assign addr3   = ADDR_W'(ptr_reg - CNT_W'(3));
    assign wr_addr = ADDR_W'(ptr_reg);
    assign wr_bank = bank_of(wr_addr);

    // Bank requests; the top word claims its bank first.
    always_comb
    begin
        req.wr_row  = row_of(wr_addr);
        req.wr_data = WORD_BITS'(push_word);
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            req.wr_en[b] = accept && push_ok && (wr_bank == BANK_W'(b));
            if (bank_of(addr1) == BANK_W'(b))
            begin
                req.rd_row[b] = row_of(addr1);
            end
            else if (bank_of(addr2) == BANK_W'(b))
            begin
                req.rd_row[b] = row_of(addr2);
            end
            else
            begin
                req.rd_row[b] = row_of(addr3);
            end
        end
    end

    // Fields of the result known now.
    assign meta.status     = status;
    assign meta.n_pop      = n_pop;
    assign meta.bank1      = bank_of(addr1);
    assign meta.bank2      = bank_of(addr2);
    assign meta.bank3      = bank_of(addr3);
    assign meta.depth      = COUNT_W'(ptr_next);
    assign meta.high_water = COUNT_W'(peak_next);

endmodule

>>> design/wshw_out_stage.sv
// ----------------------------------------------------------------------------
// wshw_out_stage
// Holds each command's fields while the bank reads complete, then routes the
// read words into the response register.
// ----------------------------------------------------------------------------
module wshw_out_stage import wshw_pkg::*; (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  item_meta_t                          meta,
    input  logic [NUM_BANKS-1:0][WORD_BITS-1:0] rd_data,
    output logic                                in_ready,
    wshw_rsp_if.source                          rsp
);

    logic       s1_valid_reg;
    item_meta_t s1_meta_reg;
    logic       out_valid_reg;
    logic       advance;

    status_t             status_reg;
    logic [DATA_W-1:0]   first_reg;
    logic [DATA_W-1:0]   second_reg;
    logic [DATA_W-1:0]   third_reg;
    logic [COUNT_W-1:0]  depth_reg;
    logic [COUNT_W-1:0]  high_water_reg;
    logic [DATA_W-1:0]   first_next;
    logic [DATA_W-1:0]   second_next;
    logic [DATA_W-1:0]   third_next;

    // The response register moves when it is empty or being taken.
    assign advance  = !out_valid_reg || rsp.ready;
    assign in_ready = !s1_valid_reg || advance;

    // Read-stage valid and fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
    end

    // Route bank outputs to word positions; words not popped read as zero.
    assign first_next  = (s1_meta_reg.n_pop >= 2'd1) ?
                         DATA_W'(rd_data[s1_meta_reg.bank1]) : '0;
    assign second_next = (s1_meta_reg.n_pop >= 2'd2) ?
                         DATA_W'(rd_data[s1_meta_reg.bank2]) : '0;
    assign third_next  = (s1_meta_reg.n_pop == 2'd3) ?
                         DATA_W'(rd_data[s1_meta_reg.bank3]) : '0;

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            status_reg     <= s1_meta_reg.status;
            first_reg      <= first_next;
            second_reg     <= second_next;
            third_reg      <= third_next;
            depth_reg      <= s1_meta_reg.depth;
            high_water_reg <= s1_meta_reg.high_water;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.first_word  = first_reg;
    assign rsp.second_word = second_reg;
    assign rsp.third_word  = third_reg;
    assign rsp.depth       = depth_reg;
    assign rsp.high_water  = high_water_reg;

endmodule

>>> design/word_stack_with_high_water_unit.sv
// ----------------------------------------------------------------------------
// word_stack_with_high_water_unit
// Word stack with a programmable limit, multi-word pop, drop, clear and a
// high-water register.
// ----------------------------------------------------------------------------
// The unit takes one command per clock while the response side is not
// stalled and returns one response per command, in order. Each command
// reads the entry banks through a registered read, and the response
// register follows the bank read. Entries live in three RAM banks
// interleaved by address, so the top three words are always in different
// banks and a pop of three reads them all in the same cycle. A stalled
// response holds the command side only once both internal stages are full.
// The limit register is written through the configuration channel, which is
// always ready, and should change only while no command is in flight.
// Entries need no clearing after reset since only written entries are ever
// returned.
module word_stack_with_high_water_unit import wshw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    wshw_cmd_if.sink   cmd,
    wshw_rsp_if.source rsp,
    wshw_cfg_if.sink   cfg
);

    logic                                accept;
    logic                                in_ready;
    item_meta_t                          meta;
    bank_req_t                           req;
    logic [NUM_BANKS-1:0][WORD_BITS-1:0] rd_data;

    assign cmd.ready = in_ready;
    assign accept    = cmd.valid && in_ready;
    assign cfg.ready = 1'b1;

    // Command decode and architectural state.
    wshw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (cmd.func),
        .push_word  (cmd.push_word),
        .drop_count (cmd.drop_count),
        .cfg_wr     (cfg.valid),
        .cfg_limit  (cfg.stack_limit),
        .meta       (meta),
        .req        (req)
    );

    // Entry banks.
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        wshw_ram #(
            .WIDTH       (WORD_BITS),
            .DEPTH_WORDS (BANK_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (req.wr_en[b]),
            .wr_addr (req.wr_row),
            .wr_data (req.wr_data),
            .rd_en   (accept),
            .rd_addr (req.rd_row[b]),
            .rd_data (rd_data[b])
        );
    end

    // Read stage and response register.
    wshw_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .meta     (meta),
        .rd_data  (rd_data),
        .in_ready (in_ready),
        .rsp      (rsp)
    );

    // The current depth never exceeds the high-water mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.depth <= rsp.high_water))
        else $error("depth above high-water mark");

    // A refused command returns no words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |->
        ((rsp.first_word == '0) && (rsp.second_word == '0) && (rsp.third_word == '0)))
        else $error("words returned on a refused command");

    // Commands are held back only by a stalled, full response register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (rsp.valid && !rsp.ready))
        else $error("command side stalled without a response stall");

    // Only a push that is accepted can raise the high-water mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.func != FN_PUSH)) |=> $stable(u_ctrl.peak_reg))
        else $error("high-water mark moved on a non-push command");

endmodule

>>> tb/sv/word_stack_checker.sv
// ----------------------------------------------------------------------------
// word_stack_checker
// Watches the command, response and limit channels of the word stack. It
// keeps its own copy of the stack, predicts the response of every accepted
// command and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module word_stack_checker import wshw_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    wshw_cmd_if    cmd,
    wshw_rsp_if    rsp,
    wshw_cfg_if    cfg,
    output int     errors,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   first_word;
        logic [DATA_W-1:0]   second_word;
        logic [DATA_W-1:0]   third_word;
        logic [COUNT_W-1:0]  depth;
        logic [COUNT_W-1:0]  high_water;
    } stack_result_t;

    // Shadow copy of the stack and its limit register.
    logic [DATA_W-1:0]  stack_mem [DEPTH];
    int                 level;
    int                 peak;
    logic [COUNT_W-1:0] limit_reg;

    // Predicted responses, oldest first.
    stack_result_t      pending_results [$];

    // Applies one operation to the shadow stack and returns its response.
    function automatic stack_result_t apply_stack_op(logic [FUNC_W-1:0]  fn,
                                                     logic [DATA_W-1:0]  word,
                                                     logic [COUNT_W-1:0] count);
        stack_result_t     r;
        logic [DATA_W-1:0] popped [3];
        int                cap;
        int                n;
        r      = '0;
        popped = '{default: '0};
        cap    = (int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg);
        n      = int'(fn);
        case (fn)
            FN_PUSH:
            begin
                if (level >= cap)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    stack_mem[level] = word;
                    level++;
                    if (level > peak)
                    begin
                        peak = level;
                    end
                end
            end
            FN_POP1, FN_POP2, FN_POP3:
            begin
                // A pop with too few words is refused and reads nothing.
                if (level < n)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        popped[k] = stack_mem[level - 1 - k];
                    end
                    level -= n;
                end
            end
            FN_DROP:
            begin
                if (int'(count) > level)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    level -= int'(count);
                end
            end
            FN_CLEAR:
            begin
                // The high-water mark survives a clear.
                level = 0;
            end
            default:
            begin
            end
        endcase
        r.first_word  = popped[0];
        r.second_word = popped[1];
        r.third_word  = popped[2];
        r.depth       = COUNT_W'(level);
        r.high_water  = COUNT_W'(peak);
        return r;
    endfunction

    task automatic check_field(string field, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Responses are handled before commands so that a response can never be
    // matched against a command accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            level     = 0;
            peak      = 0;
            limit_reg = LIMIT_RESET;
            pending_results.delete();
            outstanding = 0;
            errors      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: response word with none expected, got status %0d depth %0d",
                             $time, rsp.status, rsp.depth);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
                    check_field("first_word", want.first_word, rsp.first_word);
                    check_field("second_word", want.second_word, rsp.second_word);
                    check_field("third_word", want.third_word, rsp.third_word);
                    check_field("depth", DATA_W'(want.depth), DATA_W'(rsp.depth));
                    check_field("high_water", DATA_W'(want.high_water),
                                DATA_W'(rsp.high_water));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_results.push_back(apply_stack_op(cmd.func, cmd.push_word,
                                                         cmd.drop_count));
            end
            if (cfg.valid && cfg.ready)
            begin
                limit_reg = cfg.stack_limit;
            end
            outstanding = pending_results.size();
        end
    end

endmodule

>>> tb/sv/word_stack_with_high_water_unit_tb.sv
// ----------------------------------------------------------------------------
// word_stack_with_high_water_unit_tb
// Drives the word stack with a short directed sequence and then with random
// phases under several stack limits, with bursty commands and a stalling
// response side. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module word_stack_with_high_water_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wshw_pkg::*;

    localparam int PHASES          = 10;
    localparam int OPS_PER_PHASE   = 150;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Operation codes with no function; the block must treat them as no-ops.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE,
        SINK_BLOCKED
    } sink_mode_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   idle_cycles = 0;
    int   burst_left;

    wshw_cmd_if cmd_if ();
    wshw_rsp_if rsp_if ();
    wshw_cfg_if cfg_if ();

    word_stack_with_high_water_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    word_stack_checker stack_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .rsp         (rsp_if),
        .cfg         (cfg_if),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: stalls on a random pattern that changes at random intervals.
    initial
    begin
        sink_mode_t mode;
        int         span;
        int         hold;
        rsp_if.ready = 1'b0;
        hold = 0;
        forever
        begin
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(32, 256);
            while (span > 0)
            begin
                @(negedge clk);
                case (mode)
                    SINK_OPEN:   rsp_if.ready = 1'b1;
                    SINK_RANDOM: rsp_if.ready = 1'($urandom_range(0, 1));
                    SINK_SPARSE: rsp_if.ready = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            rsp_if.ready = 1'b0;
                            hold--;
                        end
                        else if ($urandom_range(0, 9) == 0)
                        begin
                            rsp_if.ready = 1'b0;
                            hold = $urandom_range(5, 30);
                        end
                        else
                        begin
                            rsp_if.ready = 1'b1;
                        end
                    end
                endcase
                span--;
            end
        end
    end

    // Ends the run when nothing has moved on any channel for too long.
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one command word; called and returning at a falling edge. Words go
    // out in bursts, with a random gap before each new burst.
    task automatic send_op(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] word,
                           logic [COUNT_W-1:0] count);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                cmd_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 16);
        end
        cmd_if.valid      = 1'b1;
        cmd_if.func       = fn;
        cmd_if.push_word  = word;
        cmd_if.drop_count = count;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        burst_left--;
        @(negedge clk);
    endtask

    // Lets every outstanding response come back before the limit may change.
    task automatic settle();
        cmd_if.valid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(logic [COUNT_W-1:0] value);
        cfg_if.valid       = 1'b1;
        cfg_if.stack_limit = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // One random command; push_pct sets how hard the phase fills the stack.
    task automatic random_op(int push_pct);
        logic [FUNC_W-1:0]  fn;
        logic [COUNT_W-1:0] count;
        if ($urandom_range(0, 99) < push_pct)
        begin
            fn = FN_PUSH;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: fn = FN_POP1;
                5, 6, 7, 8:    fn = FN_POP2;
                9, 10, 11, 12: fn = FN_POP3;
                13, 14, 15, 16: fn = FN_DROP;
                17, 18:        fn = FN_CLEAR;
                default:       fn = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
            endcase
        end
        // Mostly small drops, sometimes any 7-bit count.
        count = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 127))
                                            : COUNT_W'($urandom_range(0, 6));
        send_op(fn, $urandom, count);
    endtask

    initial
    begin
        logic [COUNT_W-1:0] limits [PHASES];
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FN_PUSH;
        cmd_if.push_word   = '0;
        cmd_if.drop_count  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.stack_limit = '0;
        rst_n              = 1'b0;
        burst_left         = 0;
        limits = '{7'd127, 7'd64, 7'd65, 7'd3, 7'd1, 7'd0,
                   COUNT_W'($urandom_range(1, 64)), COUNT_W'($urandom_range(1, 64)),
                   COUNT_W'($urandom_range(1, 64)), COUNT_W'($urandom_range(1, 64))};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty stack: refused pops and drops, and a drop of nothing.
        send_op(FN_POP1, '0, '0);
        send_op(FN_POP3, '0, '0);
        send_op(FN_DROP, '0, 7'd127);
        send_op(FN_DROP, 32'hFFFF_FFFF, '0);

        // Word extremes, a full pop of three, and a pop of three on two words.
        send_op(FN_PUSH, 32'h0000_0000, 7'd127);
        send_op(FN_PUSH, 32'hFFFF_FFFF, '0);
        send_op(FN_PUSH, 32'hA5A5_5A5A, '0);
        send_op(FN_POP3, '0, '0);
        send_op(FN_PUSH, 32'h0000_0001, '0);
        send_op(FN_PUSH, 32'h0000_0002, '0);
        send_op(FN_POP3, '0, '0);
        send_op(FN_POP2, '0, '0);

        // Unused codes, then a drop and a clear that must keep the high-water.
        send_op(FN_SPARE_LO, 32'hFFFF_FFFF, 7'd127);
        send_op(FN_SPARE_HI, 32'hFFFF_FFFF, 7'd127);
        send_op(FN_PUSH, 32'h1234_5678, '0);
        send_op(FN_PUSH, 32'h8765_4321, '0);
        send_op(FN_DROP, '0, 7'd1);
        send_op(FN_CLEAR, '0, '0);

        // Small limit: the third push overflows.
        settle();
        write_limit(7'd2);
        send_op(FN_PUSH, 32'hCAFE_0001, '0);
        send_op(FN_PUSH, 32'hCAFE_0002, '0);
        send_op(FN_PUSH, 32'hCAFE_0003, '0);

        // Limit lowered below the depth: pushes overflow, pops still work.
        settle();
        write_limit(7'd1);
        send_op(FN_PUSH, 32'hCAFE_0004, '0);
        send_op(FN_POP1, '0, '0);
        send_op(FN_PUSH, 32'hCAFE_0005, '0);
        send_op(FN_DROP, '0, 7'd1);

        // Zero limit: every push overflows.
        settle();
        write_limit(7'd0);
        send_op(FN_PUSH, 32'hCAFE_0006, '0);
        send_op(FN_POP2, '0, '0);

        // Random phases, alternating between filling and churning the stack.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_limit(limits[p]);
            for (int i = 0; i < OPS_PER_PHASE; i++)
            begin
                random_op((p % 2 == 0) ? 85 : 50);
            end
        end

        settle();
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
